// ----- sv/line_framer_with_line_queue_macros.svh -----
// assertion macros used by the line framer controller rtl
`ifndef LINE_FRAMER_WITH_LINE_QUEUE_MACROS_SVH
`define LINE_FRAMER_WITH_LINE_QUEUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LFQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define LFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/lfq_pkg.sv -----
package lfq_pkg;

   // line terminators
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   // operation codes
   localparam logic OP_RX   = 1'b0;
   localparam logic OP_READ = 1'b1;

   // input transaction
   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_type;

   // result transaction
   typedef struct packed {
      logic       char_valid;
      logic [7:0] out_char;
      logic       last_of_line;
      logic       queue_empty;
      logic       line_completed;
      logic       oldest_dropped;
      logic       line_overflow;
   } rsp_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } ctrl_state_type;

endpackage

// ----- sv/lfq_ram.sv -----
module lfq_ram
   #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
   )
   (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/lfq_ctrl.sv -----
`include "line_framer_with_line_queue_macros.svh"

module lfq_ctrl
   import lfq_pkg::*;
   #(
   parameter int QUEUE_DEPTH = 32,
   parameter int LINE_BYTES  = 128
   )
   (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   input  req_type                                    req,
   output logic                                       req_stall,
   input  logic                                       out_free,
   output logic                                       res_load,
   output rsp_type                                    res,
   output logic                                       store_wr_en,
   output logic [$clog2(QUEUE_DEPTH*LINE_BYTES)-1:0]  store_wr_addr,
   output logic [7:0]                                 store_wr_data,
   output logic [$clog2(QUEUE_DEPTH*LINE_BYTES)-1:0]  store_rd_addr,
   input  logic [7:0]                                 store_rd_data,
   output logic                                       len_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]             len_wr_addr,
   output logic [$clog2(LINE_BYTES)-1:0]              len_wr_data,
   output logic [$clog2(QUEUE_DEPTH)-1:0]             len_rd_addr,
   input  logic [$clog2(LINE_BYTES)-1:0]              len_rd_data
   );

   localparam int SLOT_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(LINE_BYTES);
   localparam int ADDR_W = $clog2(QUEUE_DEPTH * LINE_BYTES);

   ctrl_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  partial_ff, partial_in;
   logic [CNT_W-1:0]  offset_ff, offset_in;

   logic              accept;
   logic              is_term;
   logic              queue_empty;
   logic [SLOT_W-1:0] tail_next;
   logic [CNT_W:0]    offset_inc;

   // circular slot advance
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] nxt;
      if (slot == SLOT_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + 1'b1;
      end
      return nxt;
   endfunction

   // byte address of a character within a slot
   function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [CNT_W-1:0]  off);
      return ADDR_W'(slot) * ADDR_W'(LINE_BYTES) + ADDR_W'(off);
   endfunction

   // handshake and shared decode
   assign req_stall   = (state_ff != ST_IDLE) || !out_free;
   assign accept      = req_valid && !req_stall;
   assign is_term     = (req.rx_byte == CH_LF) || (req.rx_byte == CH_CR);
   assign queue_empty = (head_ff == tail_ff);
   assign tail_next   = next_slot(tail_ff);
   assign offset_inc  = (CNT_W+1)'(offset_ff) + (CNT_W+1)'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req.op == OP_READ) && !queue_empty) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath, memory ports and result
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      partial_in    = partial_ff;
      offset_in     = offset_ff;
      res_load      = 1'b0;
      res           = '0;
      store_wr_en   = 1'b0;
      store_wr_addr = store_addr(tail_ff, partial_ff);
      store_wr_data = req.rx_byte;
      store_rd_addr = store_addr(head_ff, offset_ff);
      len_wr_en     = 1'b0;
      len_wr_addr   = tail_ff;
      len_wr_data   = partial_ff;
      len_rd_addr   = head_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req.op == OP_RX)) begin
               res_load = 1'b1;
               if (is_term) begin
                  // close a non-empty partial line into the queue
                  if (partial_ff != '0) begin
                     len_wr_en          = 1'b1;
                     res.line_completed = 1'b1;
                     tail_in            = tail_next;
                     partial_in         = '0;
                     if (tail_next == head_ff) begin
                        head_in            = next_slot(head_ff);
                        offset_in          = '0;
                        res.oldest_dropped = 1'b1;
                     end
                  end
               end else if (partial_ff < CNT_W'(LINE_BYTES - 1)) begin
                  store_wr_en = 1'b1;
                  partial_in  = partial_ff + 1'b1;
               end else begin
                  // too long: discard the partial line
                  partial_in        = '0;
                  res.line_overflow = 1'b1;
               end
            end else if (accept && queue_empty) begin
               res_load        = 1'b1;
               res.queue_empty = 1'b1;
            end
         end
         ST_FETCH: begin
            // memory data for the read issued last cycle
            res_load       = 1'b1;
            res.char_valid = 1'b1;
            res.out_char   = store_rd_data;
            if (offset_inc >= (CNT_W+1)'(len_rd_data)) begin
               res.last_of_line = 1'b1;
               head_in          = next_slot(head_ff);
               offset_in        = '0;
            end else begin
               offset_in = offset_inc[CNT_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         partial_ff <= '0;
         offset_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         partial_ff <= partial_in;
         offset_ff  <= offset_in;
      end
   end

   `LFQ_ASSERT_NOW(a_fetch_has_room, clock, reset, (state_ff == ST_FETCH), out_free, "fetch with output occupied")
   `LFQ_ASSERT_NOW(a_fetch_gives_char, clock, reset, (state_ff == ST_FETCH), (res_load && res.char_valid), "fetch without character")
   `LFQ_ASSERT_NEXT(a_fetch_one_cycle, clock, reset, (state_ff == ST_FETCH), (state_ff == ST_IDLE), "fetch did not return to idle")
   `LFQ_ASSERT_NOW(a_empty_consistent, clock, reset, (res_load && res.queue_empty), (head_ff == tail_ff), "empty reported with lines queued")
   `LFQ_ASSERT_NOW(a_one_flag, clock, reset, res_load, $onehot0({res.char_valid, res.queue_empty, res.line_completed, res.line_overflow}), "conflicting result flags")
   `LFQ_ASSERT_NOW(a_partial_bound, clock, reset, 1'b1, (partial_ff <= CNT_W'(LINE_BYTES - 1)), "partial line past limit")

endmodule

// ----- sv/line_framer_with_line_queue.sv -----
// channel   ports                         payload
// req       req_valid req_stall req_data  req_type: op, rx_byte
// rsp       rsp_valid rsp_stall rsp_data  rsp_type: char, line and queue flags
//
// a received byte's result is registered at the accept edge; a read of a non-empty queue
// returns the next character of the oldest queued line: the line store and length memories
// have registered read ports, then the result is registered
// one transaction is in flight at a time; the next is taken once the result register
// is empty or being emptied
// synchronous active-high reset clears the queue pointers and partial line; no memory sweep
module line_framer_with_line_queue
   import lfq_pkg::*;
   #(
   parameter int QUEUE_DEPTH = 32,
   parameter int LINE_BYTES  = 128
   )
   (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
   );

   localparam int SLOT_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(LINE_BYTES);
   localparam int ADDR_W = $clog2(QUEUE_DEPTH * LINE_BYTES);

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic              out_free;
   logic              res_load;
   rsp_type           res;

   logic              store_wr_en;
   logic [ADDR_W-1:0] store_wr_addr;
   logic [7:0]        store_wr_data;
   logic [ADDR_W-1:0] store_rd_addr;
   logic [7:0]        store_rd_data;
   logic              len_wr_en;
   logic [SLOT_W-1:0] len_wr_addr;
   logic [CNT_W-1:0]  len_wr_data;
   logic [SLOT_W-1:0] len_rd_addr;
   logic [CNT_W-1:0]  len_rd_data;

   // output register is free when empty or taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   lfq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .LINE_BYTES  (LINE_BYTES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req           (req_data),
      .req_stall     (req_stall),
      .out_free      (out_free),
      .res_load      (res_load),
      .res           (res),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data),
      .len_wr_en     (len_wr_en),
      .len_wr_addr   (len_wr_addr),
      .len_wr_data   (len_wr_data),
      .len_rd_addr   (len_rd_addr),
      .len_rd_data   (len_rd_data)
   );

   // character storage, one row of LINE_BYTES per slot
   lfq_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH * LINE_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // length of each queued line
   lfq_ram #(
      .WIDTH (CNT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_line_length (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (len_wr_addr),
      .wr_data (len_wr_data),
      .rd_addr (len_rd_addr),
      .rd_data (len_rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
